/* design/tto_pkg.sv */
// tto_pkg: action, unit and status codes, register indexes and the
// divider constants for the tick timeout checker.
// No dependencies; used by tto_watch and tick_timeout_checker.
package tto_pkg;

   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [1:0] ACTION_ADD   = 2'd0;
   localparam logic [1:0] ACTION_START = 2'd1;
   localparam logic [1:0] ACTION_CHECK = 2'd2;

   localparam logic [1:0] UNITS_TICKS = 2'd0;
   localparam logic [1:0] UNITS_USEC  = 2'd1;
   localparam logic [1:0] UNITS_MSEC  = 2'd2;
   localparam logic [1:0] UNITS_SEC   = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT     = 2'd1;
   localparam logic [1:0] STATUS_NOT_RUNNING = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_BASE        = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVOCATION_LIMIT = 1'd1;

   localparam logic [DATA_WIDTH-1:0] TIME_BASE_DEFAULT = 32'd1;
   localparam logic [DATA_WIDTH-1:0] LIMIT_DEFAULT     = 32'd1000000;

   // x / 1000 = (x * MAGIC_MSEC) >> 38, x / 1000000 = (x * MAGIC_SEC) >> 50,
   // exact for every 32-bit x
   localparam logic [DATA_WIDTH-1:0] MAGIC_MSEC = 32'd274877907;
   localparam logic [DATA_WIDTH-1:0] MAGIC_SEC  = 32'd1125899907;
   localparam int unsigned SHIFT_MSEC = 38;
   localparam int unsigned SHIFT_SEC  = 50;

   typedef struct packed {
      logic                  scale;
      logic [1:0]            base_status;
      logic [DATA_WIDTH-1:0] tick_count;
      logic [DATA_WIDTH-1:0] elapsed;
   } watch_type;

   typedef struct packed {
      watch_type             watch;
      logic [1:0]            units;
      logic [DATA_WIDTH-1:0] timeout_time;
   } stage_type;

endpackage

/* design/tto_watch.sv */
// tto_watch: tick counter, start mark and stall watchdog state.
// Updates state on each accepted request and reports the per-request view.
// Depends on tto_pkg.
module tto_watch (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [1:0]                       action,
   input  logic [tto_pkg::DATA_WIDTH-1:0]   tick_amount,
   input  logic [tto_pkg::DATA_WIDTH-1:0]   invocation_limit,
   output tto_pkg::watch_type               watch
);

   logic [tto_pkg::DATA_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [tto_pkg::DATA_WIDTH-1:0] start_mark_ff, start_mark_in;
   logic [tto_pkg::DATA_WIDTH-1:0] last_seen_ff, last_seen_in;
   logic [tto_pkg::DATA_WIDTH-1:0] stall_checks_ff, stall_checks_in;
   logic [tto_pkg::DATA_WIDTH-1:0] stall_next;
   logic                           stalled;

   assign stall_next = (last_seen_ff == tick_count_ff) ? stall_checks_ff + 32'd1 : '0;
   assign stalled    = stall_next > invocation_limit;

   always_comb begin
      tick_count_in   = tick_count_ff;
      start_mark_in   = start_mark_ff;
      last_seen_in    = last_seen_ff;
      stall_checks_in = stall_checks_ff;
      watch.scale       = 1'b0;
      watch.base_status = tto_pkg::STATUS_OK;
      watch.elapsed     = tick_count_ff - start_mark_ff;
      unique case (action)
         tto_pkg::ACTION_ADD: begin
            tick_count_in = tick_count_ff + tick_amount;
         end
         tto_pkg::ACTION_START: begin
            start_mark_in   = tick_count_ff;
            last_seen_in    = tick_count_ff;
            stall_checks_in = '0;
         end
         tto_pkg::ACTION_CHECK: begin
            stall_checks_in = stall_next;
            if (stalled) begin
               watch.base_status = tto_pkg::STATUS_NOT_RUNNING;
            end else begin
               last_seen_in = tick_count_ff;
               watch.scale  = 1'b1;
            end
         end
         default: begin
         end
      endcase
      watch.tick_count = tick_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         start_mark_ff   <= '0;
         last_seen_ff    <= '0;
         stall_checks_ff <= '0;
      end else if (accept) begin
         tick_count_ff   <= tick_count_in;
         start_mark_ff   <= start_mark_in;
         last_seen_ff    <= last_seen_in;
         stall_checks_ff <= stall_checks_in;
      end
   end

endmodule

/* design/tick_timeout_checker.sv */
// tick_timeout_checker: timeout timer with stall watchdog, top level.
// Depends on tto_pkg and tto_watch.
//
// Usage:
//   req channel (req_valid / req_stall) carries one request: action, tick
//   amount, units and timeout time. rsp channel (rsp_valid / rsp_stall)
//   returns exactly one response per request, in order: status, tick count
//   after the request and the elapsed time in the requested units.
//   csr_write_enable writes csr_write_data to register csr_index
//   (0 time base, 1 invocation limit); a zero write loads the default.
//   Throughput: one request per cycle while rsp is not stalled. Timer state
//   is updated at accept; the scaling runs in a four-register pipeline
//   (elapsed, product with the time base, reciprocal product for the
//   constant divide, result). Reset clears the counters, loads the
//   register defaults and empties the pipeline. A stalled rsp holds its
//   result; requests are still taken while the pipeline has an empty
//   stage, and req_stall rises once all stages are full.
module tick_timeout_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [tto_pkg::DATA_WIDTH-1:0]        req_tick_amount,
   input  logic [1:0]                            req_units,
   input  logic [tto_pkg::DATA_WIDTH-1:0]        req_timeout_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [tto_pkg::DATA_WIDTH-1:0]        rsp_tick_count,
   output logic [tto_pkg::DATA_WIDTH-1:0]        rsp_elapsed_scaled,
   input  logic                                  csr_write_enable,
   input  logic [tto_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tto_pkg::DATA_WIDTH-1:0]        csr_write_data
);

   logic [tto_pkg::DATA_WIDTH-1:0] time_base_ff;
   logic [tto_pkg::DATA_WIDTH-1:0] limit_ff;

   logic accept;
   logic out_free, s3_free, s2_free, s1_free;
   tto_pkg::watch_type watch;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   tto_pkg::stage_type s1_ff, s2_ff, s3_ff;
   logic [tto_pkg::DATA_WIDTH-1:0]   s2_prod_ff, s3_prod_ff;
   logic [2*tto_pkg::DATA_WIDTH-1:0] s3_recip_ff, s3_recip_in;
   logic [tto_pkg::DATA_WIDTH-1:0]   magic;

   logic [tto_pkg::DATA_WIDTH-1:0] quot;
   logic [tto_pkg::DATA_WIDTH-1:0] scaled;
   logic [1:0]                     status_in, rsp_status_ff;
   logic [tto_pkg::DATA_WIDTH-1:0] elapsed_in, rsp_tick_count_ff, rsp_elapsed_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff <= tto_pkg::TIME_BASE_DEFAULT;
         limit_ff     <= tto_pkg::LIMIT_DEFAULT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tto_pkg::CSR_TIME_BASE: begin
               time_base_ff <= (csr_write_data == '0) ? tto_pkg::TIME_BASE_DEFAULT
                                                      : csr_write_data;
            end
            tto_pkg::CSR_INVOCATION_LIMIT: begin
               limit_ff <= (csr_write_data == '0) ? tto_pkg::LIMIT_DEFAULT
                                                  : csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   tto_watch u_watch (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .action           (req_action),
      .tick_amount      (req_tick_amount),
      .invocation_limit (limit_ff),
      .watch            (watch)
   );

   assign magic       = (s2_ff.units == tto_pkg::UNITS_MSEC) ? tto_pkg::MAGIC_MSEC
                                                             : tto_pkg::MAGIC_SEC;
   assign s3_recip_in = 64'(s2_prod_ff) * 64'(magic);

   always_comb begin
      quot = (s3_ff.units == tto_pkg::UNITS_MSEC) ? 32'(s3_recip_ff >> tto_pkg::SHIFT_MSEC)
                                                  : 32'(s3_recip_ff >> tto_pkg::SHIFT_SEC);
      case (s3_ff.units)
         tto_pkg::UNITS_TICKS: scaled = s3_ff.watch.elapsed;
         tto_pkg::UNITS_USEC:  scaled = s3_prod_ff;
         default:              scaled = quot;
      endcase
      if (s3_ff.watch.scale) begin
         elapsed_in = scaled;
         status_in  = (scaled < s3_ff.timeout_time) ? tto_pkg::STATUS_OK
                                                    : tto_pkg::STATUS_TIMEOUT;
      end else begin
         elapsed_in = '0;
         status_in  = s3_ff.watch.base_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= accept;
         if (s2_free) s2_valid_ff <= s1_valid_ff;
         if (s3_free) s3_valid_ff <= s2_valid_ff;
         if (out_free) rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ff.watch        <= watch;
         s1_ff.units        <= req_units;
         s1_ff.timeout_time <= req_timeout_time;
      end
      if (s2_free) begin
         s2_ff      <= s1_ff;
         s2_prod_ff <= s1_ff.watch.elapsed * time_base_ff;
      end
      if (s3_free) begin
         s3_ff       <= s2_ff;
         s3_prod_ff  <= s2_prod_ff;
         s3_recip_ff <= s3_recip_in;
      end
      if (out_free) begin
         rsp_status_ff     <= status_in;
         rsp_tick_count_ff <= s3_ff.watch.tick_count;
         rsp_elapsed_ff    <= elapsed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_tick_count     = rsp_tick_count_ff;
   assign rsp_elapsed_scaled = rsp_elapsed_ff;

`ifndef SYNTHESIS
   a_not_running_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tto_pkg::STATUS_NOT_RUNNING |-> rsp_elapsed_scaled == '0)
      else $error("not-running response with nonzero elapsed time");

   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff)
      else $error("request stalled while a pipeline stage is empty");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_free |=> s3_valid_ff && $stable(s3_recip_ff) && $stable(s3_ff))
      else $error("last stage changed while blocked");
`endif

endmodule

/* verif/tick_timeout_checker_test.sv */
// tick_timeout_checker_test: self-checking bench for the tick timeout checker.
// Drives requests and register writes, predicts each response and compares it.
// Depends on tto_pkg and the tick_timeout_checker RTL.
module tick_timeout_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  ACTION_UNUSED = 2'd3;
   localparam int unsigned MSEC_DIV      = 1000;
   localparam int unsigned SEC_DIV       = 1000000;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [1:0]                     action;
      logic [tto_pkg::DATA_WIDTH-1:0] amount;
      logic [1:0]                     units;
      logic [tto_pkg::DATA_WIDTH-1:0] timeout;
   } timer_request_type;

   typedef struct packed {
      logic [1:0]                     status;
      logic [tto_pkg::DATA_WIDTH-1:0] tick_count;
      logic [tto_pkg::DATA_WIDTH-1:0] elapsed;
   } timer_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [1:0]                          req_action = tto_pkg::ACTION_ADD;
   logic [tto_pkg::DATA_WIDTH-1:0]      req_tick_amount = '0;
   logic [1:0]                          req_units = tto_pkg::UNITS_TICKS;
   logic [tto_pkg::DATA_WIDTH-1:0]      req_timeout_time = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [1:0]                          rsp_status;
   logic [tto_pkg::DATA_WIDTH-1:0]      rsp_tick_count;
   logic [tto_pkg::DATA_WIDTH-1:0]      rsp_elapsed_scaled;
   logic                                csr_write_enable = 1'b0;
   logic [tto_pkg::CSR_INDEX_WIDTH-1:0] csr_index = tto_pkg::CSR_TIME_BASE;
   logic [tto_pkg::DATA_WIDTH-1:0]      csr_write_data = '0;

   timer_request_type pending_requests[$];
   timer_result_type  expected_results[$];

   // predicted timer state and registers
   logic [tto_pkg::DATA_WIDTH-1:0] base_reg    = tto_pkg::TIME_BASE_DEFAULT;
   logic [tto_pkg::DATA_WIDTH-1:0] limit_reg   = tto_pkg::LIMIT_DEFAULT;
   logic [tto_pkg::DATA_WIDTH-1:0] count_now   = '0;
   logic [tto_pkg::DATA_WIDTH-1:0] mark        = '0;
   logic [tto_pkg::DATA_WIDTH-1:0] seen_count  = '0;
   logic [tto_pkg::DATA_WIDTH-1:0] idle_checks = '0;

   // counter and start mark as the stimulus plan sees them
   logic [tto_pkg::DATA_WIDTH-1:0] plan_count = '0;
   logic [tto_pkg::DATA_WIDTH-1:0] plan_mark  = '0;

   bit req_fire = 1'b0;
   bit calm     = 1'b0;
   int gap_left   = 0;
   int stall_left = 0;
   int queued_items = 0;
   int mismatches = 0;
   int requests_taken = 0;
   int responses_checked = 0;
   int timeouts_seen = 0;
   int not_running_seen = 0;

   tick_timeout_checker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_tick_amount    (req_tick_amount),
      .req_units          (req_units),
      .req_timeout_time   (req_timeout_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_tick_count     (rsp_tick_count),
      .rsp_elapsed_scaled (rsp_elapsed_scaled),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [tto_pkg::DATA_WIDTH-1:0] scaled_time(
         logic [tto_pkg::DATA_WIDTH-1:0] elapsed,
         logic [1:0]                     units,
         logic [tto_pkg::DATA_WIDTH-1:0] base);
      logic [63:0]                    product;
      logic [tto_pkg::DATA_WIDTH-1:0] usec;
      product = 64'(elapsed) * 64'(base);
      usec = product[tto_pkg::DATA_WIDTH-1:0];
      case (units)
         tto_pkg::UNITS_TICKS: return elapsed;
         tto_pkg::UNITS_USEC:  return usec;
         tto_pkg::UNITS_MSEC:  return usec / MSEC_DIV;
         default:              return usec / SEC_DIV;
      endcase
   endfunction

   task automatic apply_request(timer_request_type r);
      timer_result_type e;
      e = '0;
      e.status = tto_pkg::STATUS_OK;
      case (r.action)
         tto_pkg::ACTION_ADD: begin
            count_now = count_now + r.amount;
         end
         tto_pkg::ACTION_START: begin
            mark = count_now;
            idle_checks = '0;
            seen_count = count_now;
         end
         tto_pkg::ACTION_CHECK: begin
            if (seen_count == count_now) idle_checks = idle_checks + 1;
            else idle_checks = '0;
            if (idle_checks > limit_reg) begin
               e.status = tto_pkg::STATUS_NOT_RUNNING;
            end else begin
               seen_count = count_now;
               e.elapsed = scaled_time(count_now - mark, r.units, base_reg);
               e.status = (e.elapsed < r.timeout) ? tto_pkg::STATUS_OK
                                                  : tto_pkg::STATUS_TIMEOUT;
            end
         end
         default: ;
      endcase
      e.tick_count = count_now;
      expected_results.push_back(e);
   endtask

   task automatic report_mismatch(string what, logic [tto_pkg::DATA_WIDTH-1:0] got,
                                  logic [tto_pkg::DATA_WIDTH-1:0] want);
      $display("ERROR %0t: %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   // request driver
   always @(negedge clock) begin
      timer_request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_action <= r.action;
            req_tick_amount <= r.amount;
            req_units <= r.units;
            req_timeout_time <= r.timeout;
            if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
         stall_left = $urandom_range(1, 15);
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   // request and response monitor
   always @(posedge clock) begin
      timer_result_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         apply_request({req_action, req_tick_amount, req_units, req_timeout_time});
         requests_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_tick_count, '0);
         end else begin
            want = expected_results.pop_front();
            responses_checked++;
            if (want.status == tto_pkg::STATUS_TIMEOUT) timeouts_seen++;
            if (want.status == tto_pkg::STATUS_NOT_RUNNING) not_running_seen++;
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_tick_count !== want.tick_count)
               report_mismatch("tick_count", rsp_tick_count, want.tick_count);
            if (rsp_elapsed_scaled !== want.elapsed)
               report_mismatch("elapsed_scaled", rsp_elapsed_scaled, want.elapsed);
         end
      end
   end

   task automatic queue_request(logic [1:0] action, logic [tto_pkg::DATA_WIDTH-1:0] amount,
                                logic [1:0] units,
                                logic [tto_pkg::DATA_WIDTH-1:0] timeout);
      timer_request_type r;
      r = {action, amount, units, timeout};
      if (action == tto_pkg::ACTION_ADD) plan_count = plan_count + amount;
      if (action == tto_pkg::ACTION_START) plan_mark = plan_count;
      if (action != ACTION_UNUSED) queued_items++;
      pending_requests.push_back(r);
   endtask

   // check whose threshold often sits right at the expected elapsed time
   task automatic queue_check();
      logic [1:0]                     units;
      logic [tto_pkg::DATA_WIDTH-1:0] near;
      logic [tto_pkg::DATA_WIDTH-1:0] timeout;
      units = 2'($urandom_range(0, 3));
      near = scaled_time(plan_count - plan_mark, units, base_reg);
      case ($urandom_range(0, 5))
         0: timeout = near;
         1: timeout = near + 1;
         2: timeout = near - 1;
         3: timeout = '0;
         4: timeout = '1;
         default: timeout = $urandom;
      endcase
      queue_request(tto_pkg::ACTION_CHECK, $urandom, units, timeout);
   endtask

   function automatic logic [tto_pkg::DATA_WIDTH-1:0] pick_amount();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom_range(1, 100);
         2: return $urandom_range(1, 5000000);
         3: return '1 - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_random(int target);
      int steps;
      while (queued_items < target) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_request(tto_pkg::ACTION_START, $urandom, 2'($urandom), $urandom);
            steps = $urandom_range(1, 8);
            repeat (steps) begin
               case ($urandom_range(0, 5))
                  0, 1: queue_request(tto_pkg::ACTION_ADD, pick_amount(), 2'($urandom),
                                      $urandom);
                  2, 3: queue_check();
                  4: repeat ($urandom_range(1, 8)) queue_check();
                  default: begin
                     queue_request(tto_pkg::ACTION_ADD, '0, 2'($urandom), $urandom);
                     queue_check();
                  end
               endcase
            end
         end else begin
            queue_request(2'($urandom), $urandom, 2'($urandom), $urandom);
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [tto_pkg::CSR_INDEX_WIDTH-1:0] index,
                            logic [tto_pkg::DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == tto_pkg::CSR_TIME_BASE)
         base_reg = (data == '0) ? tto_pkg::TIME_BASE_DEFAULT : data;
      else
         limit_reg = (data == '0) ? tto_pkg::LIMIT_DEFAULT : data;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a zero time base write loads its default, stall watchdog, wraparound, all units
      write_csr(tto_pkg::CSR_TIME_BASE, '0);
      write_csr(tto_pkg::CSR_INVOCATION_LIMIT, 32'd2);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, 32'd1);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, '1);
      queue_request(ACTION_UNUSED, '1, tto_pkg::UNITS_SEC, '1);
      queue_request(tto_pkg::ACTION_ADD, '1, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_START, '0, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_ADD, 32'd5, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_USEC, '1);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_MSEC, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_SEC, '0);
      queue_request(tto_pkg::ACTION_ADD, '1, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, 32'd4);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, 32'd5);
      queue_request(tto_pkg::ACTION_ADD, '0, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, '1);
      queue_request(tto_pkg::ACTION_START, '0, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_TICKS, '1);
      queue_request(tto_pkg::ACTION_ADD, 32'd2000000, tto_pkg::UNITS_TICKS, '0);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_SEC, 32'd2);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_MSEC, 32'd2001);
      queue_request(tto_pkg::ACTION_CHECK, '0, tto_pkg::UNITS_USEC, 32'd2000000);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(tto_pkg::CSR_TIME_BASE, '1);
               write_csr(tto_pkg::CSR_INVOCATION_LIMIT, 32'd1);
            end
            1: begin
               write_csr(tto_pkg::CSR_TIME_BASE, 32'd1000);
               write_csr(tto_pkg::CSR_INVOCATION_LIMIT, 32'd3);
            end
            2: begin
               write_csr(tto_pkg::CSR_TIME_BASE, 32'd1000000);
               write_csr(tto_pkg::CSR_INVOCATION_LIMIT, '0);
            end
            3: begin
               write_csr(tto_pkg::CSR_TIME_BASE, $urandom);
               write_csr(tto_pkg::CSR_INVOCATION_LIMIT, '1);
            end
            4: begin
               write_csr(tto_pkg::CSR_TIME_BASE, 32'd1);
               write_csr(tto_pkg::CSR_INVOCATION_LIMIT, $urandom_range(2, 6));
            end
            default: begin
               calm = 1'b1;
               write_csr(tto_pkg::CSR_TIME_BASE, $urandom_range(1, 5000));
               write_csr(tto_pkg::CSR_INVOCATION_LIMIT, $urandom_range(1, 8));
            end
         endcase
         queue_random(queued_items + 215);
         wait_idle();
      end

      $display("Checked %0d responses to %0d requests over seven register settings;",
               responses_checked, requests_taken);
      $display("%0d timed out and %0d reported the timer as not running.",
               timeouts_seen, not_running_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timed out waiting for responses");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
